### src/cpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared widths, constants and pipeline types of the circle point generator.
// ----------------------------------------------------------------------------
package cpts_pkg;

	localparam int MAG_W = 33;
	localparam int X2_W  = 32;
	localparam int SUM_W = 36;
	localparam int P_W   = 36;
	localparam int AD_W  = 24;
	localparam int AX_W  = 31;
	localparam int FRAC  = 30;
	localparam int X2_FRAC = 28;
	localparam int REC_W = P_W + 1;

	localparam longint unsigned HALF_TURN  = 64'd11796480;
	localparam longint unsigned FULL_TURN  = 64'd23592960;
	localparam longint unsigned ROUND_HALF = 64'd5898240;
	localparam longint unsigned PI_A       = 64'd37480660;
	localparam longint unsigned PI_B       = 64'd13;
	localparam longint unsigned RECIP45    = 64'd381774871;
	localparam int RECIP45_SH = 34;
	localparam int DEG_SH     = 18;

	localparam int REG_RADIUS   = 0;
	localparam int REG_CENTER_X = 1;
	localparam int REG_CENTER_Y = 2;

	typedef struct packed {
		logic [MAG_W-1:0]        mag;
		logic                    neg;
		logic signed [SUM_W-1:0] sum;
	} lane_t;

	typedef struct packed {
		logic            valid;
		logic [X2_W-1:0] x2;
		lane_t           sin_l;
		lane_t           cos_l;
	} item_t;

endpackage
`default_nettype wire

### src/cpts_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_term
// One series step for sine and cosine: multiply by x squared, divide by the
// step's constant denominator and accumulate, over three register stages.
// ----------------------------------------------------------------------------
module cpts_term #(
	parameter int unsigned STEP = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire cpts_pkg::item_t d,
	output cpts_pkg::item_t     q
);
	import cpts_pkg::*;

	localparam longint unsigned SIN_DEN = 64'(2 * STEP) * 64'(2 * STEP + 1);
	localparam longint unsigned COS_DEN = 64'(2 * STEP - 1) * 64'(2 * STEP);
	localparam int SIN_K = P_W + $clog2(SIN_DEN);
	localparam int COS_K = P_W + $clog2(COS_DEN);
	localparam longint unsigned SIN_M = ((64'd1 << SIN_K) + SIN_DEN - 64'd1) / SIN_DEN;
	localparam longint unsigned COS_M = ((64'd1 << COS_K) + COS_DEN - 64'd1) / COS_DEN;
	localparam int HALF = P_W / 2;
	localparam int PP_W = HALF + REC_W;
	localparam int FULL_W = P_W + REC_W + 1;

	logic [MAG_W+X2_W-1:0] sprod, cprod;
	logic                  v_s1;
	logic [X2_W-1:0]       x2_s1;
	logic [P_W-1:0]        sp_s1, cp_s1;
	logic                  sn_s1, cn_s1;
	logic signed [SUM_W-1:0] ss_s1, cs_s1;

	logic                  v_s2;
	logic [X2_W-1:0]       x2_s2;
	logic [PP_W-1:0]       shi_s2, slo_s2, chi_s2, clo_s2;
	logic                  sn_s2, cn_s2;
	logic signed [SUM_W-1:0] ss_s2, cs_s2;

	logic [FULL_W-1:0]     sfull, cfull, sq, cq;
	logic signed [SUM_W-1:0] sadd, cadd;

	assign sprod = MAG_W'(d.sin_l.mag) * X2_W'(d.x2);
	assign cprod = MAG_W'(d.cos_l.mag) * X2_W'(d.x2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= d.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1  <= d.x2;
			sp_s1  <= sprod[P_W+X2_FRAC-1:X2_FRAC];
			cp_s1  <= cprod[P_W+X2_FRAC-1:X2_FRAC];
			sn_s1  <= ~d.sin_l.neg;
			cn_s1  <= ~d.cos_l.neg;
			ss_s1  <= d.sin_l.sum;
			cs_s1  <= d.cos_l.sum;
			x2_s2  <= x2_s1;
			shi_s2 <= PP_W'(sp_s1[P_W-1:HALF]) * PP_W'(REC_W'(SIN_M));
			slo_s2 <= PP_W'(sp_s1[HALF-1:0]) * PP_W'(REC_W'(SIN_M));
			chi_s2 <= PP_W'(cp_s1[P_W-1:HALF]) * PP_W'(REC_W'(COS_M));
			clo_s2 <= PP_W'(cp_s1[HALF-1:0]) * PP_W'(REC_W'(COS_M));
			sn_s2  <= sn_s1;
			cn_s2  <= cn_s1;
			ss_s2  <= ss_s1;
			cs_s2  <= cs_s1;
		end
	end

	assign sfull = (FULL_W'(shi_s2) << HALF) + FULL_W'(slo_s2);
	assign cfull = (FULL_W'(chi_s2) << HALF) + FULL_W'(clo_s2);
	assign sq    = sfull >> SIN_K;
	assign cq    = cfull >> COS_K;
	assign sadd  = $signed(SUM_W'(sq[MAG_W-1:0]));
	assign cadd  = $signed(SUM_W'(cq[MAG_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid     <= v_s2;
			q.x2        <= x2_s2;
			q.sin_l.mag <= sq[MAG_W-1:0];
			q.sin_l.neg <= sn_s2;
			q.sin_l.sum <= sn_s2 ? ss_s2 - sadd : ss_s2 + sadd;
			q.cos_l.mag <= cq[MAG_W-1:0];
			q.cos_l.neg <= cn_s2;
			q.cos_l.sum <= cn_s2 ? cs_s2 - cadd : cs_s2 + cadd;
		end
	end

endmodule
`default_nettype wire

### src/circle_point_taylor_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_point_taylor_sincos
// Maps an angle in degrees to the pixel at that angle on a circle.
// ----------------------------------------------------------------------------
// Input words carry angle_deg, unsigned Q9.16 degrees. Output words carry
// point_x and point_y, the circle point truncated toward zero.
// Radius and center are set through the write port; the user must write them
// only while the block is idle, as the block itself does not enforce it. The
// block is a pipeline of 3*SERIES_TERMS+4 register stages. It takes one word
// per cycle while the output is not stalled; each series term after the first
// costs three stages (multiply, reciprocal multiply, accumulate).
// Reset empties the pipeline and loads radius 200 and center (400, 300).
// When the receiver holds tready low with a word waiting, the whole
// pipeline holds and the input tready drops; no word is lost or repeated.
// ----------------------------------------------------------------------------
module circle_point_taylor_sincos #(
	parameter int SERIES_TERMS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // angle_deg[24:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // point_x[13:0], point_y[27:14]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	import cpts_pkg::*;

	localparam int V_W = SUM_W + 13;

	logic        en;
	logic [10:0] radius_q;
	logic [11:0] center_x_q, center_y_q;

	logic [24:0]     angle;
	logic [25:0]     red;
	logic            v_s1, v_s2, v_s3, v_s4;
	logic            n_s1, n_s2, n_s3, n_s4;
	logic [AD_W-1:0] ad_s1;
	logic [49:0]     pa_s2, pa_s3;
	logic [27:0]     rv_s2;
	logic [56:0]     rprod;
	logic [21:0]     rq_s3;
	logic [49:0]     tsum;
	logic [AX_W-1:0] ax_s4;
	logic [61:0]     axsq;
	logic [MAG_W-1:0] smag;
	item_t           item_s5;
	item_t           link [SERIES_TERMS];

	logic                  v_o1;
	logic signed [V_W-1:0] vx_o1, vy_o1;
	logic signed [V_W-1:0] vx, vy;
	logic [V_W-1:0]        ax_abs, ay_abs;
	logic [13:0]           px, py;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 11'd200;
			center_x_q <= 12'd400;
			center_y_q <= 12'd300;
		end else if (cfg_we) begin
			unique case (int'(cfg_index))
				REG_RADIUS:   radius_q   <= cfg_data[10:0];
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign angle = s_axis_tdata[24:0];
	assign red   = (64'(angle) >= HALF_TURN) ? {1'b0, angle} - 26'(FULL_TURN) : {1'b0, angle};
	assign rprod = 57'(rv_s2) * 57'(RECIP45);
	assign tsum  = pa_s3 + 50'(rq_s3);
	assign axsq  = 62'(ax_s4) * 62'(ax_s4);
	assign smag  = {1'b0, ax_s4, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			item_s5 <= '0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			item_s5.valid     <= v_s4;
			item_s5.x2        <= axsq[61:30];
			item_s5.sin_l.mag <= smag;
			item_s5.sin_l.neg <= n_s4;
			item_s5.sin_l.sum <= n_s4 ? -$signed(SUM_W'(smag)) : $signed(SUM_W'(smag));
			item_s5.cos_l.mag <= MAG_W'(1) << FRAC;
			item_s5.cos_l.neg <= 1'b0;
			item_s5.cos_l.sum <= SUM_W'(1) << FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= red[25];
			ad_s1 <= red[25] ? AD_W'(-red) : red[AD_W-1:0];
			n_s2  <= n_s1;
			pa_s2 <= 50'(ad_s1) * 50'(PI_A);
			rv_s2 <= 28'(28'(ad_s1) * 28'(PI_B) + 28'(ROUND_HALF));
			n_s3  <= n_s2;
			pa_s3 <= pa_s2;
			rq_s3 <= rprod[RECIP45_SH+21:RECIP45_SH];
			n_s4  <= n_s3;
			ax_s4 <= tsum[DEG_SH+AX_W-1:DEG_SH];
		end
	end

	assign link[0] = item_s5;

	for (genvar i = 1; i < SERIES_TERMS; i++) begin : g_term
		cpts_term #(.STEP(i)) u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (link[i-1]),
			.q      (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o1 <= 1'b0;
		end else if (en) begin
			v_o1 <= link[SERIES_TERMS-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_o1 <= $signed(V_W'(radius_q)) * $signed(V_W'(link[SERIES_TERMS-1].cos_l.sum))
				+ $signed(V_W'({center_x_q, 30'b0}));
			vy_o1 <= $signed(V_W'(radius_q)) * $signed(V_W'(link[SERIES_TERMS-1].sin_l.sum))
				+ $signed(V_W'({center_y_q, 30'b0}));
		end
	end

	assign vx     = vx_o1;
	assign vy     = vy_o1;
	assign ax_abs = vx[V_W-1] ? V_W'(-vx) : V_W'(vx);
	assign ay_abs = vy[V_W-1] ? V_W'(-vy) : V_W'(vy);
	assign px     = vx[V_W-1] ? 14'(-ax_abs[V_W-1:FRAC]) : ax_abs[FRAC+13:FRAC];
	assign py     = vy[V_W-1] ? 14'(-ay_abs[V_W-1:FRAC]) : ay_abs[FRAC+13:FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_o1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {4'b0, py, px};
		end
	end

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_stall_holds_front: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s1 |=> v_s1 && $stable(ad_s1))
		else $error("front stage changed during stall");

	a_cos_first_term: assert property (@(posedge clk) disable iff (!arst_n)
		item_s5.valid |-> item_s5.cos_l.sum == (SUM_W'(1) << FRAC))
		else $error("cosine series does not start at one");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted word did not enter the pipeline");

endmodule
`default_nettype wire

### verif/tb_circle_point_taylor_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_point_taylor_sincos
// Self-checking regression of the Taylor series circle point generator.
// ----------------------------------------------------------------------------
// Angle words are streamed in with random gaps while the output side stalls at
// random. Each accepted angle is turned into an expected pixel by an
// independent fixed-point model of the series; output words are compared in
// order. Radius and center are swept through several settings between phases.
// ----------------------------------------------------------------------------
module tb_circle_point_taylor_sincos;
	import cpts_pkg::*;

	localparam int TERMS   = 12;
	localparam int LATENCY = 3 * TERMS + 4;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [13:0] px;
		logic signed [13:0] py;
	} pixel_t;

	class pixel_scoreboard;
		pixel_t pending[$];
		int unsigned rad, cx, cy;
		int errors, checked;

		function new();
			rad = 200;
			cx = 400;
			cy = 300;
		endfunction

		function longint series(longint unsigned x2, longint unsigned mag0,
				bit neg0, bit odd);
			longint unsigned mag, k, den;
			bit neg;
			longint acc;
			mag = mag0;
			neg = neg0;
			acc = neg ? -longint'(mag) : longint'(mag);
			for (int i = 1; i < TERMS; i++) begin
				k = 2 * i;
				den = odd ? k * (k + 1) : (k - 1) * k;
				mag = ((mag * x2) >> 28) / den;
				neg = !neg;
				acc += neg ? -longint'(mag) : longint'(mag);
			end
			return acc;
		endfunction

		function logic [13:0] to_pixel(longint trig, longint unsigned ctr);
			longint v, p;
			v = longint'(rad) * trig + longint'(ctr << 30);
			if (v < 0)
				p = -longint'(longint'(-v) >>> 30);
			else
				p = v >>> 30;
			return p[13:0];
		endfunction

		function void note_angle(logic [24:0] ang);
			longint d;
			longint unsigned ad, ax, x2;
			bit neg;
			pixel_t e;
			d = ang;
			if (d >= 11796480)
				d -= 23592960;
			neg = d < 0;
			ad = neg ? -d : d;
			ax = (ad * 64'd1686629713 + 64'd5898240) / 64'd11796480;
			x2 = (ax * ax) >> 30;
			e.px = to_pixel(series(x2, 64'd1 << 30, 0, 0), cx);
			e.py = to_pixel(series(x2, ax << 1, neg, 1), cy);
			pending.insert(pending.size(), e);
		endfunction

		function void check_pixel(logic [31:0] w);
			pixel_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output word %h", w);
				return;
			end
			e = pending.pop_front();
			if (w[13:0] !== e.px || w[27:14] !== e.py) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
						e.px, e.py, $signed(w[13:0]), $signed(w[27:14]));
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [31:0] s_axis_tdata, m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [11:0] cfg_data;

	pixel_scoreboard sb;
	bit quiet_tail, long_hold, timed_out;
	int idle_cycles, sent;

	circle_point_taylor_sincos #(.SERIES_TERMS(TERMS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		arst_n = 0;
		sb = new();
	end

	// Output side: random stall bursts, one long hold-off, none at the tail.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_pixel(m_axis_tdata);
		end
	end

	initial begin
		int n;
		@(posedge clk);
		while (1) begin
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("circle_point_taylor_sincos regression: fail");
			$finish;
		end
	end

	task automatic send_angle(input logic [24:0] ang, input bit gaps);
		int n;
		if (gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 7);
			s_axis_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, ang};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_angle(ang);
		sent++;
	endtask

	task automatic drain_all();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_RADIUS:   sb.rad = val[10:0];
			REG_CENTER_X: sb.cx = val;
			REG_CENTER_Y: sb.cy = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_angle(output logic [24:0] ang);
		case ($urandom_range(0, 9))
			0: ang = 25'($urandom());
			1: ang = 25'(25'd23592960 + $urandom_range(0, 9961471));
			2: ang = 25'(25'd11796480 + $urandom_range(0, 3) - 2);
			default: ang = 25'($urandom_range(0, 23592960));
		endcase
	endtask

	initial begin
		logic [24:0] ang;
		logic [24:0] directed[$];
		int unsigned settings[6][3];
		settings = '{'{200, 400, 300}, '{2047, 4095, 4095}, '{0, 0, 0},
			'{2047, 0, 0}, '{1, 2047, 1}, '{1234, 2048, 2047}};
		directed = '{25'd0, 25'd1, 25'd5898240, 25'd11796479, 25'd11796480,
			25'd11796481, 25'd17694720, 25'd23592959, 25'd23592960,
			25'd23592961, 25'h1FFFFFF, 25'h1555555, 25'h0AAAAAA, 25'd2949120,
			25'd8847360, 25'd14745600, 25'd20643840, 25'h1000000};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_angle(directed[i], 0);
		drain_all();
		for (int p = 0; p < 6; p++) begin
			write_reg(2'(REG_RADIUS), 12'(settings[p][0]));
			write_reg(2'(REG_CENTER_X), 12'(settings[p][1]));
			write_reg(2'(REG_CENTER_Y), 12'(settings[p][2]));
			foreach (directed[i])
				send_angle(directed[i], 1);
			if (p == 1)
				long_hold = 1;
			if (p == 5)
				quiet_tail = 1;
			for (int i = 0; i < 150; i++) begin
				random_angle(ang);
				send_angle(ang, 1);
			end
			drain_all();
		end
		$display("Sent %0d angle words over six radius/center settings,", sent);
		$display("including the wrap boundaries and a long output stall.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("circle_point_taylor_sincos regression: pass");
		else
			$display("circle_point_taylor_sincos regression: fail");
		$finish;
	end
endmodule

### filelist.f
src/cpts_pkg.sv
src/cpts_term.sv
src/circle_point_taylor_sincos.sv
verif/tb_circle_point_taylor_sincos.sv
